@@ design/gcd_pkg.sv @@
// shared types and constants for the binary gcd block
`default_nettype none

package gcd_pkg;

    // operand and result width
    localparam int WIDTH = 32;
    // width of the power-of-two shift count (common factors of two)
    localparam int SHIFT_W = $clog2(WIDTH);
    // slave-side tdata: two operands, padded to whole bytes
    localparam int IN_DATA_W = ((2 * WIDTH + 7) / 8) * 8;
    // master-side tdata: one result, padded to whole bytes
    localparam int OUT_DATA_W = ((WIDTH + 7) / 8) * 8;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;     // take a new operand pair
        logic step;     // one reduction step
        logic capture;  // move the finished result into the output register
    } t_gcd_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic done;     // one operand has reached zero
    } t_gcd_sts;

endpackage

`default_nettype wire

@@ design/gcd_datapath.sv @@
// operand registers, reduction step logic and output register of the gcd
`default_nettype none

module gcd_datapath
    import gcd_pkg::*;
(
    input  wire logic             i_clk,
    input  wire t_gcd_cmd         i_cmd,
    input  wire logic [WIDTH-1:0] i_first_value,
    input  wire logic [WIDTH-1:0] i_second_value,
    output t_gcd_sts              o_sts,
    output logic [WIDTH-1:0]      o_divisor
);

    logic [WIDTH-1:0]   r_a;
    logic [WIDTH-1:0]   r_b;
    logic [SHIFT_W-1:0] r_k;
    logic [WIDTH-1:0]   r_out;
    logic [WIDTH-1:0]   n_a;
    logic [WIDTH-1:0]   n_b;
    logic [SHIFT_W-1:0] n_k;
    logic [WIDTH-1:0]   w_a_minus_b;
    logic [WIDTH-1:0]   w_b_minus_a;
    logic               w_a_ge_b;
    logic [WIDTH-1:0]   w_result;

    // differences for the odd-odd case
    assign w_a_minus_b = r_a - r_b;
    assign w_b_minus_a = r_b - r_a;
    assign w_a_ge_b    = (r_a >= r_b);

    // with one operand zero the other holds the gcd with the common factors of two removed
    assign w_result = (r_a | r_b) << r_k;

    // load a new pair or take one binary reduction step; gcd(a,b) << k is kept by each step
    always_comb begin
        n_a = r_a;
        n_b = r_b;
        n_k = r_k;
        if (i_cmd.load) begin
            n_a = i_first_value;
            n_b = i_second_value;
            n_k = '0;
        end else if (i_cmd.step) begin
            if (!r_a[0] && !r_b[0]) begin
                // common factor of two
                n_a = r_a >> 1;
                n_b = r_b >> 1;
                n_k = r_k + SHIFT_W'(1);
            end else if (!r_a[0]) begin
                n_a = r_a >> 1;
            end else if (!r_b[0]) begin
                n_b = r_b >> 1;
            end else if (w_a_ge_b) begin
                // difference of two odd values is even
                n_a = w_a_minus_b >> 1;
            end else begin
                n_b = w_b_minus_a >> 1;
            end
        end
    end

    // operand and output registers
    always_ff @(posedge i_clk) begin
        r_a <= n_a;
        r_b <= n_b;
        r_k <= n_k;
        if (i_cmd.capture) begin
            r_out <= w_result;
        end
    end

    assign o_sts.done = (r_a == '0) || (r_b == '0);
    assign o_divisor  = r_out;

endmodule

`default_nettype wire

@@ design/gcd_control.sv @@
// controller state machine and output valid flag of the gcd
`default_nettype none

module gcd_control
    import gcd_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    input  wire t_gcd_sts i_sts,
    output t_gcd_cmd      o_cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic r_state;
    logic n_state;
    logic r_out_valid;
    logic n_out_valid;
    logic w_out_free;

    // output register can take a result this cycle
    assign w_out_free = !r_out_valid || i_out_ready;

    // next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_RUN;
                end
            end
            ST_RUN: begin
                if (i_sts.done) begin
                    if (w_out_free) begin
                        o_cmd.capture = 1'b1;
                        n_state       = ST_IDLE;
                    end
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // output valid: set on capture, cleared when the transaction completes
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.capture) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

@@ design/gcd_euclid_remainder.sv @@
// Greatest common divisor of two unsigned 32-bit operands. One transaction on
// the slave side yields one result on the master side, in order. The pair is
// reduced by binary steps (halve an even operand, or replace the larger odd
// operand by half the difference), one step per clock in the operand
// registers, and the common power of two is restored by a shift at the end.
// An item is loaded, reduced until one operand is zero, and moved into the
// output register once that is free; the step count depends on the operand
// values. If either operand is zero the result is the other operand, and
// gcd(0,0) is 0. One pair is worked on at a time; the next pair is taken
// while the previous result waits in the output register.
`default_nettype none

module gcd_euclid_remainder
    import gcd_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // [31:0] first_value, [63:32] second_value
    input  wire logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    // [31:0] divisor
    output logic [OUT_DATA_W-1:0]      o_m_axis_tdata
);

    t_gcd_cmd         w_cmd;
    t_gcd_sts         w_sts;
    logic [WIDTH-1:0] w_divisor;

    // sequencing and handshake
    gcd_control u_control (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // operand reduction
    gcd_datapath u_datapath (
        .i_clk          (i_clk),
        .i_cmd          (w_cmd),
        .i_first_value  (i_s_axis_tdata[WIDTH-1:0]),
        .i_second_value (i_s_axis_tdata[2*WIDTH-1:WIDTH]),
        .o_sts          (w_sts),
        .o_divisor      (w_divisor)
    );

    assign o_m_axis_tdata = OUT_DATA_W'(w_divisor);

endmodule

`default_nettype wire

@@ design/gcd_checker.sv @@
// port-level checks of the gcd block and their binding to the top level
`default_nettype none

module gcd_checker
    import gcd_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_s_axis_tvalid,
    input wire logic                  o_s_axis_tready,
    input wire logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    input wire logic                  o_m_axis_tvalid,
    input wire logic                  i_m_axis_tready,
    input wire logic [OUT_DATA_W-1:0] o_m_axis_tdata
);

    // a pending result stays valid until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> o_m_axis_tvalid)
        else $error("result dropped before transaction");

    // a pending result keeps its value
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    // one pair at a time: the slave side closes after a transaction
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("second pair accepted while busy");

    // a new result shows up only when the engine is back to taking input
    a_result_frees_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> o_s_axis_tready)
        else $error("result presented while engine still busy");

endmodule

bind gcd_euclid_remainder gcd_checker u_gcd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

`default_nettype wire
